>>> rtl/pelc_pkg.sv
// pelc_pkg: shared types, codes and sizes for the pin entry lock controller
// no dependencies; every other rtl file refers to it by scoped names
`default_nettype none

package pelc_pkg;

	// entry buffer size and shortest usable pin
	localparam int PIN_DIGITS = 8;
	localparam int MIN_DIGITS = 4;
	// the stored pin register holds eight nibbles
	localparam int STORE_NIBBLES = 8;
	localparam int PIN_CAP = (PIN_DIGITS < STORE_NIBBLES) ? PIN_DIGITS : STORE_NIBBLES;

	localparam int IDX_W = $clog2(PIN_DIGITS);
	localparam int CNT_W = $clog2(PIN_DIGITS + 1);

	// field and register widths
	localparam int FUNC_W     = 3;
	localparam int DIGIT_W    = 4;
	localparam int PIN_W      = 32;
	localparam int LEN_W      = 4;
	localparam int ATT_W      = 4;
	localparam int TICK_W     = 20;
	localparam int OUTCOME_W  = 3;
	localparam int ENTERED_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [LEN_W-1:0]  RST_PIN_LENGTH   = LEN_W'(0);
	localparam logic [ATT_W-1:0]  RST_MAX_ATTEMPTS = ATT_W'(5);
	localparam logic [TICK_W-1:0] RST_LOCKOUT      = TICK_W'(30000);
	localparam logic [ATT_W-1:0]  ATT_MAX          = '1;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX       = DIGIT_W'(9);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_DIGIT     = 3'd0,
		FUNC_BACKSPACE = 3'd1,
		FUNC_OK        = 3'd2,
		FUNC_TICK      = 3'd3,
		FUNC_LOCK      = 3'd4
	} pelc_func_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_IGNORED = 3'd0,
		OUT_ENTRY   = 3'd1,
		OUT_UNLOCK  = 3'd2,
		OUT_WRONG   = 3'd3,
		OUT_LOCKOUT = 3'd4
	} pelc_outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIN_DIGITS    = 2'd0,
		REG_PIN_LENGTH    = 2'd1,
		REG_MAX_ATTEMPTS  = 2'd2,
		REG_LOCKOUT_TICKS = 2'd3
	} pelc_reg_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [PIN_W-1:0]  pin_digits;
		logic [CNT_W-1:0]  stored_len;
		logic [ATT_W-1:0]  max_attempts;
		logic [TICK_W-1:0] lockout_ticks;
	} pelc_cfg_t;

	// one result word
	typedef struct packed {
		logic                 locked;
		logic [ENTERED_W-1:0] entered_count;
		logic [ATT_W-1:0]     attempts;
		logic                 lockout_active;
		logic [TICK_W-1:0]    remaining_ticks;
		pelc_outcome_t        outcome;
	} pelc_result_t;

endpackage

`default_nettype wire

>>> rtl/pelc_if.sv
// pelc_if: valid/ready channels for key events and status words
// depends on pelc_pkg for field widths
`default_nettype none

interface pelc_evt_if;
	logic                            valid;
	logic                            ready;
	logic [pelc_pkg::FUNC_W-1:0]     func;
	logic [pelc_pkg::DIGIT_W-1:0]    digit;

	modport source (output valid, output func, output digit, input ready);
	modport sink   (input valid, input func, input digit, output ready);
endinterface

interface pelc_status_if;
	logic                             valid;
	logic                             ready;
	logic                             locked;
	logic [pelc_pkg::ENTERED_W-1:0]   entered_count;
	logic [pelc_pkg::ATT_W-1:0]       attempts;
	logic                             lockout_active;
	logic [pelc_pkg::TICK_W-1:0]      remaining_ticks;
	logic [pelc_pkg::OUTCOME_W-1:0]   outcome;

	modport source (output valid, output locked, output entered_count, output attempts,
		output lockout_active, output remaining_ticks, output outcome, input ready);
	modport sink   (input valid, input locked, input entered_count, input attempts,
		input lockout_active, input remaining_ticks, input outcome, output ready);
endinterface

`default_nettype wire

>>> rtl/pelc_cfg_regs.sv
// pelc_cfg_regs: configuration registers and effective pin length
// depends on pelc_pkg
`default_nettype none

module pelc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pelc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pelc_pkg::CFG_DATA_W-1:0] cfg_data,
	output pelc_pkg::pelc_cfg_t                  cfg
);

	logic [pelc_pkg::PIN_W-1:0]  pin_digits_q;
	logic [pelc_pkg::LEN_W-1:0]  pin_length_q;
	logic [pelc_pkg::ATT_W-1:0]  max_attempts_q;
	logic [pelc_pkg::TICK_W-1:0] lockout_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_digits_q    <= '0;
			pin_length_q    <= pelc_pkg::RST_PIN_LENGTH;
			max_attempts_q  <= pelc_pkg::RST_MAX_ATTEMPTS;
			lockout_ticks_q <= pelc_pkg::RST_LOCKOUT;
		end else if (cfg_we) begin
			unique case (pelc_pkg::pelc_reg_t'(cfg_index))
				pelc_pkg::REG_PIN_DIGITS:    pin_digits_q    <= cfg_data[pelc_pkg::PIN_W-1:0];
				pelc_pkg::REG_PIN_LENGTH:    pin_length_q    <= cfg_data[pelc_pkg::LEN_W-1:0];
				pelc_pkg::REG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_data[pelc_pkg::ATT_W-1:0];
				pelc_pkg::REG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_data[pelc_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// short lengths mean no pin, long ones clamp to the entry size
	logic [pelc_pkg::CNT_W-1:0] len_clamped;
	always_comb begin
		if (32'(pin_length_q) < 32'(pelc_pkg::MIN_DIGITS))
			len_clamped = '0;
		else if (32'(pin_length_q) > 32'(pelc_pkg::PIN_CAP))
			len_clamped = pelc_pkg::CNT_W'(pelc_pkg::PIN_CAP);
		else
			len_clamped = pelc_pkg::CNT_W'(pin_length_q);
	end

	assign cfg.pin_digits    = pin_digits_q;
	assign cfg.stored_len    = len_clamped;
	assign cfg.max_attempts  = max_attempts_q;
	assign cfg.lockout_ticks = lockout_ticks_q;

endmodule

`default_nettype wire

>>> rtl/pelc_match.sv
// pelc_match: per-digit compare of the entry against the stored pin
// depends on pelc_pkg
`default_nettype none

module pelc_match (
	input  wire logic [pelc_pkg::DIGIT_W-1:0] view [pelc_pkg::PIN_DIGITS],
	input  wire logic [pelc_pkg::PIN_W-1:0]   pin_digits,
	input  wire logic [pelc_pkg::CNT_W-1:0]   stored_len,
	output logic                              match
);

	logic [pelc_pkg::PIN_DIGITS-1:0] lane_ok;

	for (genvar i = 0; i < pelc_pkg::PIN_DIGITS; i++) begin : g_lane
		localparam int NIB = i % pelc_pkg::STORE_NIBBLES;
		// lanes past the pin length do not take part
		assign lane_ok[i] = (pelc_pkg::CNT_W'(i) >= stored_len)
			|| (view[i] == pin_digits[4*NIB +: 4]);
	end

	assign match = (stored_len != '0) && (&lane_ok);

endmodule

`default_nettype wire

>>> rtl/pelc_step.sv
// pelc_step: lock state, entry buffer and per-event next-state logic
// depends on pelc_pkg and pelc_match
`default_nettype none

module pelc_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [pelc_pkg::FUNC_W-1:0]   func,
	input  wire logic [pelc_pkg::DIGIT_W-1:0]  digit,
	input  wire pelc_pkg::pelc_cfg_t           cfg,
	output pelc_pkg::pelc_result_t             result
);

	logic [pelc_pkg::DIGIT_W-1:0] entry_q [pelc_pkg::PIN_DIGITS];
	logic [pelc_pkg::CNT_W-1:0]   count_q, count_n;
	logic                         lock_q, lock_n;
	logic [pelc_pkg::ATT_W-1:0]   wrong_q, wrong_n, wrong_inc;
	logic [pelc_pkg::TICK_W-1:0]  lockout_q, lockout_n;

	logic                         keys_open, append, do_check, match;
	pelc_pkg::pelc_outcome_t      outcome;
	logic [pelc_pkg::DIGIT_W-1:0] view [pelc_pkg::PIN_DIGITS];

	// entry as it stands after a digit is appended
	for (genvar i = 0; i < pelc_pkg::PIN_DIGITS; i++) begin : g_view
		assign view[i] = (append && count_q[pelc_pkg::IDX_W-1:0] == pelc_pkg::IDX_W'(i))
			? digit : entry_q[i];
	end

	pelc_match u_match (
		.view       (view),
		.pin_digits (cfg.pin_digits),
		.stored_len (cfg.stored_len),
		.match      (match)
	);

	assign keys_open = lock_q && (lockout_q == '0);
	assign wrong_inc = (wrong_q != pelc_pkg::ATT_MAX) ? wrong_q + 1'b1 : wrong_q;

	always_comb begin
		count_n   = count_q;
		lock_n    = lock_q;
		wrong_n   = wrong_q;
		lockout_n = lockout_q;
		outcome   = pelc_pkg::OUT_IGNORED;
		append    = 1'b0;
		do_check  = 1'b0;

		unique case (pelc_pkg::pelc_func_t'(func))
			pelc_pkg::FUNC_DIGIT: begin
				if (keys_open && digit <= pelc_pkg::DIGIT_MAX
						&& 32'(count_q) < 32'(pelc_pkg::PIN_DIGITS)) begin
					append  = 1'b1;
					count_n = count_q + 1'b1;
					outcome = pelc_pkg::OUT_ENTRY;
					do_check = (count_n == cfg.stored_len);
				end
			end
			pelc_pkg::FUNC_BACKSPACE: begin
				if (keys_open && count_q != '0) begin
					count_n = count_q - 1'b1;
					outcome = pelc_pkg::OUT_ENTRY;
				end
			end
			pelc_pkg::FUNC_OK: begin
				do_check = keys_open && 32'(count_q) >= 32'(pelc_pkg::MIN_DIGITS);
			end
			pelc_pkg::FUNC_TICK: begin
				if (lockout_q != '0) begin
					lockout_n = lockout_q - 1'b1;
					if (lockout_n == '0)
						wrong_n = '0;
				end
			end
			pelc_pkg::FUNC_LOCK: begin
				if (cfg.stored_len != '0) begin
					lock_n  = 1'b1;
					count_n = '0;
					outcome = pelc_pkg::OUT_ENTRY;
				end
			end
			default: ;
		endcase

		if (do_check) begin
			if (match && count_n == cfg.stored_len) begin
				lock_n  = 1'b0;
				wrong_n = '0;
				outcome = pelc_pkg::OUT_UNLOCK;
			end else if (wrong_inc >= cfg.max_attempts) begin
				lockout_n = cfg.lockout_ticks;
				wrong_n   = (cfg.lockout_ticks == '0) ? '0 : wrong_inc;
				outcome   = pelc_pkg::OUT_LOCKOUT;
			end else begin
				wrong_n = wrong_inc;
				outcome = pelc_pkg::OUT_WRONG;
			end
			count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			lock_q    <= 1'b0;
			wrong_q   <= '0;
			lockout_q <= '0;
		end else if (accept) begin
			count_q   <= count_n;
			lock_q    <= lock_n;
			wrong_q   <= wrong_n;
			lockout_q <= lockout_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && append)
			entry_q[count_q[pelc_pkg::IDX_W-1:0]] <= digit;
	end

	assign result.locked          = lock_n;
	assign result.entered_count   = pelc_pkg::ENTERED_W'(count_n);
	assign result.attempts        = wrong_n;
	assign result.lockout_active  = (lockout_n != '0);
	assign result.remaining_ticks = lockout_n;
	assign result.outcome         = outcome;

endmodule

`default_nettype wire

>>> rtl/pin_entry_lock_controller_core.sv
// pin_entry_lock_controller_core: top level of the keypad pin lock
// depends on pelc_pkg, pelc_if, pelc_cfg_regs, pelc_step (which uses pelc_match)
`default_nettype none

// Keypad pin lock with wrong-entry lockout. Each word on key_evt is one
// event (digit, backspace, ok, millisecond tick, lock request) and gives
// exactly one status word on status, in order. At the edge that accepts it,
// the lock state is updated and its status word is loaded into the output
// register. key_evt.ready stays high while the output register is empty or
// being drained, so with status always ready the block takes one event every
// cycle. The pin compare is a row of eight nibble comparators fed from the
// entry buffer, with the incoming digit muxed in at the current count, which
// sets the longest path. Configuration must be written through
// cfg_we/cfg_index/cfg_data while no event is in flight, which the block
// does not check; writes never touch the entry, the lock or the counters.
module pin_entry_lock_controller_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pelc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pelc_pkg::CFG_DATA_W-1:0] cfg_data,
	pelc_evt_if.sink                             key_evt,
	pelc_status_if.source                        status
);

	pelc_pkg::pelc_cfg_t    cfg;
	pelc_pkg::pelc_result_t result;
	pelc_pkg::pelc_result_t res_q;
	logic                   out_valid_q;
	logic                   accept;

	// register file plus clamped pin length
	pelc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// take a new word whenever the output slot is free or emptying now
	assign key_evt.ready = !out_valid_q || status.ready;
	assign accept        = key_evt.valid && key_evt.ready;

	// event decode, pin check and state registers
	pelc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.func   (key_evt.func),
		.digit  (key_evt.digit),
		.cfg    (cfg),
		.result (result)
	);

	// output register: holds the status word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= result;
	end

	assign status.valid           = out_valid_q;
	assign status.locked          = res_q.locked;
	assign status.entered_count   = res_q.entered_count;
	assign status.attempts        = res_q.attempts;
	assign status.lockout_active  = res_q.lockout_active;
	assign status.remaining_ticks = res_q.remaining_ticks;
	assign status.outcome         = res_q.outcome;

endmodule

`default_nettype wire

>>> tb/sv/tb_pelc_status_check.sv
`timescale 1ns / 100ps
// tb_pelc_status_check: watches the key event, status and register ports of the pin lock,
// keeps its own copy of the lock state and compares every status word with the prediction
// depends on pelc_pkg and pelc_if
module tb_pelc_status_check (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pelc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pelc_pkg::CFG_DATA_W-1:0] cfg_data,
	pelc_evt_if                                  key_evt,
	pelc_status_if                               status,
	output int                                   fail_count,
	output int                                   words_owed
);
	import pelc_pkg::*;

	// register copy
	logic [PIN_W-1:0]   m_pin;
	logic [LEN_W-1:0]   m_len;
	logic [ATT_W-1:0]   m_max;
	logic [TICK_W-1:0]  m_ticks;

	// lock state copy
	logic [DIGIT_W-1:0] m_entry [PIN_DIGITS];
	logic [3:0]         m_count;
	logic               m_engaged;
	logic [ATT_W-1:0]   m_wrong;
	logic [TICK_W-1:0]  m_left;

	pelc_result_t status_owed [$];
	int fails = 0;
	int owed_n = 0;

	assign fail_count = fails;
	assign words_owed = owed_n;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fails++;
		$display("status mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	// pin length as the lock uses it: short means no pin, long saturates
	function automatic logic [3:0] pin_len_eff();
		if (m_len < MIN_DIGITS)
			return 4'd0;
		if (m_len > PIN_CAP)
			return 4'(PIN_CAP);
		return m_len;
	endfunction

	function automatic pelc_outcome_t judge_entry();
		logic [3:0] len;
		logic       hit;
		len = pin_len_eff();
		hit = (len != 0) && (m_count == len);
		for (int i = 0; i < PIN_CAP; i++)
			if (hit && i < len && m_entry[i] != m_pin[4*i +: 4])
				hit = 1'b0;
		m_count = 4'd0;
		if (hit) begin
			m_engaged = 1'b0;
			m_wrong   = '0;
			return OUT_UNLOCK;
		end
		if (m_wrong != ATT_MAX)
			m_wrong = m_wrong + 1'b1;
		if (m_wrong >= m_max) begin
			m_left = m_ticks;
			if (m_left == 0)
				m_wrong = '0;
			return OUT_LOCKOUT;
		end
		return OUT_WRONG;
	endfunction

	function automatic pelc_result_t apply_key_event(input logic [FUNC_W-1:0] f,
			input logic [DIGIT_W-1:0] d);
		pelc_result_t  r;
		pelc_outcome_t res;
		logic          keys_open;
		res       = OUT_IGNORED;
		keys_open = m_engaged && (m_left == 0);
		case (f)
			FUNC_DIGIT: begin
				if (keys_open && d <= DIGIT_MAX && m_count < PIN_DIGITS) begin
					m_entry[m_count[IDX_W-1:0]] = d;
					m_count = m_count + 1'b1;
					res = OUT_ENTRY;
					if (m_count == pin_len_eff())
						res = judge_entry();
				end
			end
			FUNC_BACKSPACE: begin
				if (keys_open && m_count > 0) begin
					m_count = m_count - 1'b1;
					res = OUT_ENTRY;
				end
			end
			FUNC_OK: begin
				if (keys_open && m_count >= MIN_DIGITS)
					res = judge_entry();
			end
			FUNC_TICK: begin
				if (m_left != 0) begin
					m_left = m_left - 1'b1;
					if (m_left == 0)
						m_wrong = '0;
				end
			end
			FUNC_LOCK: begin
				if (pin_len_eff() != 0) begin
					m_engaged = 1'b1;
					m_count   = 4'd0;
					res       = OUT_ENTRY;
				end
			end
			default: ;
		endcase
		r.locked          = m_engaged;
		r.entered_count   = m_count;
		r.attempts        = m_wrong;
		r.lockout_active  = (m_left != 0);
		r.remaining_ticks = m_left;
		r.outcome         = res;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pelc_result_t owed;
		if (!arst_n) begin
			m_pin     = '0;
			m_len     = RST_PIN_LENGTH;
			m_max     = RST_MAX_ATTEMPTS;
			m_ticks   = RST_LOCKOUT;
			for (int i = 0; i < PIN_DIGITS; i++)
				m_entry[i] = '0;
			m_count   = 4'd0;
			m_engaged = 1'b0;
			m_wrong   = '0;
			m_left    = '0;
			status_owed.delete();
		end else begin
			if (status.valid && status.ready) begin
				if (status_owed.size() == 0) begin
					report_mismatch("unexpected status word, outcome", status.outcome, 0);
				end else begin
					owed = status_owed.pop_front();
					if (status.locked !== owed.locked)
						report_mismatch("locked", status.locked, owed.locked);
					if (status.entered_count !== owed.entered_count)
						report_mismatch("entered_count", status.entered_count, owed.entered_count);
					if (status.attempts !== owed.attempts)
						report_mismatch("attempts", status.attempts, owed.attempts);
					if (status.lockout_active !== owed.lockout_active)
						report_mismatch("lockout_active", status.lockout_active,
							owed.lockout_active);
					if (status.remaining_ticks !== owed.remaining_ticks)
						report_mismatch("remaining_ticks", status.remaining_ticks,
							owed.remaining_ticks);
					if (status.outcome !== owed.outcome)
						report_mismatch("outcome", status.outcome, owed.outcome);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PIN_DIGITS:    m_pin   = cfg_data[PIN_W-1:0];
					REG_PIN_LENGTH:    m_len   = cfg_data[LEN_W-1:0];
					REG_MAX_ATTEMPTS:  m_max   = cfg_data[ATT_W-1:0];
					REG_LOCKOUT_TICKS: m_ticks = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (key_evt.valid && key_evt.ready) begin
				owed = apply_key_event(key_evt.func, key_evt.digit);
				status_owed.push_back(owed);
			end
		end
		owed_n = status_owed.size();
	end

endmodule

>>> tb/sv/tb_pin_entry_lock_controller_core.sv
`timescale 1ns / 100ps
// tb_pin_entry_lock_controller_core: stimulus and verdict for the keypad pin lock
// depends on pelc_pkg, pelc_if, the core and tb_pelc_status_check
module tb_pin_entry_lock_controller_core;
	import pelc_pkg::*;

	// hard stop, far beyond the slowest correct run
	localparam int RUN_LIMIT = 1_000_000;
	// func codes 5 to 7 are not events
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int fails;
	int owed;
	int cycles     = 0;
	int words_sent = 0;
	bit no_gaps    = 1'b0;

	// what was last written to the registers, so well-formed pins can be keyed
	logic [PIN_W-1:0] cur_pin = '0;
	logic [LEN_W-1:0] cur_len = RST_PIN_LENGTH;

	pelc_evt_if    key_evt ();
	pelc_status_if status ();

	pin_entry_lock_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key_evt   (key_evt),
		.status    (status)
	);

	tb_pelc_status_check status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key_evt    (key_evt),
		.status     (status),
		.fail_count (fails),
		.words_owed (owed)
	);

	always #5 clk = ~clk;

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [DIGIT_W-1:0] rand_digit();
		return DIGIT_W'($urandom_range(0, 15));
	endfunction

	// eight nibbles, decimal only unless wide is set
	function automatic logic [PIN_W-1:0] rand_pin(input bit wide);
		logic [PIN_W-1:0] p;
		p = '0;
		for (int i = 0; i < 8; i++)
			p[4*i +: 4] = wide ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
		return p;
	endfunction

	// offer one key event word and hold it until it is taken; starts and ends at a negedge
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [DIGIT_W-1:0] d);
		int gap;
		key_evt.valid <= 1'b1;
		key_evt.func  <= f;
		key_evt.digit <= d;
		do
			@(posedge clk);
		while (!key_evt.ready);
		words_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			// valid stays high into the next call when there is no gap
			key_evt.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// key the stored pin; short lengths still key four digits, long ones eight
	task automatic send_pin();
		int n;
		n = int'(cur_len);
		if (n < MIN_DIGITS)
			n = MIN_DIGITS;
		if (n > PIN_CAP)
			n = PIN_CAP;
		for (int i = 0; i < n; i++)
			send_word(FUNC_DIGIT, cur_pin[4*i +: 4]);
	endtask

	// stop offering and wait for every owed status word
	task automatic settle();
		key_evt.valid <= 1'b0;
		while (owed != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// write all four registers back to back; unused upper data bits carry noise
	task automatic program_regs(input logic [PIN_W-1:0] pin, input logic [LEN_W-1:0] len,
			input logic [ATT_W-1:0] max_att, input logic [TICK_W-1:0] ticks);
		cur_pin = pin;
		cur_len = len;
		cfg_we    <= 1'b1;
		cfg_index <= REG_PIN_DIGITS;
		cfg_data  <= pin;
		@(negedge clk);
		cfg_index <= REG_PIN_LENGTH;
		cfg_data  <= {$urandom} & ~32'hF | 32'(len);
		@(negedge clk);
		cfg_index <= REG_MAX_ATTEMPTS;
		cfg_data  <= {$urandom} & ~32'hF | 32'(max_att);
		@(negedge clk);
		cfg_index <= REG_LOCKOUT_TICKS;
		cfg_data  <= {$urandom} & ~32'hFFFFF | 32'(ticks);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly well-formed key sequences with random content, the rest noise
	task automatic run_random_phase(input int quota, input bit steady);
		int start;
		int kind;
		start = words_sent;
		while (words_sent - start < quota) begin
			no_gaps = steady || ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				send_word(FUNC_LOCK, rand_digit());
			end else if (kind < 42) begin
				// right pin, often right after a lock request
				if ($urandom_range(0, 1))
					send_word(FUNC_LOCK, rand_digit());
				send_pin();
				if ($urandom_range(0, 3) == 0)
					send_word(FUNC_OK, rand_digit());
			end else if (kind < 62) begin
				// guessed digits, maybe confirmed with ok
				repeat ($urandom_range(1, PIN_DIGITS + 1))
					send_word(FUNC_DIGIT, DIGIT_W'($urandom_range(0, 9)));
				if ($urandom_range(0, 1))
					send_word(FUNC_OK, rand_digit());
			end else if (kind < 76) begin
				// run down a lockout
				repeat ($urandom_range(1, 24))
					send_word(FUNC_TICK, rand_digit());
			end else if (kind < 86) begin
				// typo, correction, then the pin
				repeat ($urandom_range(1, 3))
					send_word(FUNC_DIGIT, DIGIT_W'($urandom_range(0, 9)));
				repeat ($urandom_range(1, 4))
					send_word(FUNC_BACKSPACE, rand_digit());
				send_pin();
			end else begin
				repeat ($urandom_range(1, 3))
					send_word(FUNC_W'($urandom_range(0, 7)), rand_digit());
			end
		end
		no_gaps = 1'b0;
	endtask

	// status side: random stalls, calm stretches, and two long hold-offs
	initial begin : sink_side
		int   stall_left;
		int   age;
		logic rdy;
		stall_left = 0;
		age        = 0;
		status.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			age++;
			if (age == 1500 || age == 4000) begin
				// long hold-off: output register stays full and key_evt must back up
				stall_left = 400;
			end else if (stall_left == 0 && (age / 300) % 3 != 0
					&& $urandom_range(0, 99) < 12) begin
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
			end
			if (stall_left > 0) begin
				rdy = 1'b0;
				stall_left--;
			end else begin
				rdy = 1'b1;
			end
			status.ready <= rdy;
		end
	end

	initial begin : stimulus
		key_evt.valid = 1'b0;
		key_evt.func  = FUNC_TICK;
		key_evt.digit = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset registers: no pin, so lock requests and keys do nothing
		send_word(FUNC_LOCK, 4'd0);
		send_word(FUNC_DIGIT, 4'd5);
		send_word(FUNC_TICK, 4'd0);
		settle();

		// pin 1234, lockout after two wrong entries, two ticks long
		program_regs(32'h0000_4321, 4'd4, 4'd2, 20'd2);
		send_word(FUNC_LOCK, 4'd0);
		send_word(FUNC_BACKSPACE, 4'd0);   // empty entry
		send_word(FUNC_DIGIT, 4'd12);      // digit above nine
		send_word(FUNC_OK, 4'd0);          // entry too short
		send_word(FUNC_DIGIT, 4'd1);
		send_word(FUNC_DIGIT, 4'd2);
		send_word(FUNC_DIGIT, 4'd3);
		send_word(FUNC_DIGIT, 4'd9);       // checked at full length, wrong
		send_word(FUNC_DIGIT, 4'd1);
		send_word(FUNC_DIGIT, 4'd2);
		send_word(FUNC_DIGIT, 4'd3);
		send_word(FUNC_DIGIT, 4'd5);       // second wrong entry starts lockout
		send_word(FUNC_DIGIT, 4'd1);       // blocked
		send_word(FUNC_LOCK, 4'd0);        // lock request still taken during lockout
		send_word(FUNC_TICK, 4'd0);
		send_word(FUNC_TICK, 4'd0);        // lockout ends, attempts cleared
		send_pin();                        // unlock
		send_word(FUNC_OK, 4'd0);          // keys while unlocked
		send_word(FUNC_LOCK, 4'd0);
		settle();

		// engaged, then the pin made too short: no auto check, entry fills up
		program_regs(32'h0000_4321, 4'd2, 4'd0, 20'd0);
		repeat (PIN_DIGITS + 1)
			send_word(FUNC_DIGIT, 4'd7);    // last one hits a full entry
		send_word(FUNC_OK, 4'd0);          // always wrong; zero max and zero ticks
		send_word(FUNC_UNUSED, 4'd15);
		settle();

		// random phases over several register settings, extremes included
		program_regs(32'h0000_0000, 4'd4, 4'd1, 20'd1);
		run_random_phase(165, 1'b0);
		settle();
		program_regs(rand_pin(1'b0), 4'd8, 4'd15, 20'($urandom_range(1, 30)));
		run_random_phase(165, 1'b0);
		settle();
		program_regs(rand_pin(1'b0), 4'($urandom_range(5, 7)), 4'd0, 20'd0);
		run_random_phase(165, 1'b0);
		settle();
		program_regs(32'hFFFF_FFFF, 4'd3, 4'($urandom_range(1, 15)),
			20'($urandom_range(1, 30)));
		run_random_phase(165, 1'b0);
		settle();
		program_regs(rand_pin(1'b1), 4'd15, 4'($urandom_range(1, 15)),
			20'($urandom_range(1, 30)));
		run_random_phase(165, 1'b0);
		settle();
		program_regs(rand_pin(1'b1), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			20'($urandom_range(0, 30)));
		run_random_phase(165, 1'b1);
		settle();
		program_regs(rand_pin(1'b0), 4'd4, 4'd2, 20'd20);
		run_random_phase(165, 1'b0);
		settle();
		// longest lockout last: once started it outlasts the run
		program_regs(rand_pin(1'b0), 4'd4, 4'd1, '1);
		run_random_phase(165, 1'b0);
		settle();

		repeat (5) @(negedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/pelc_pkg.sv
rtl/pelc_if.sv
rtl/pelc_cfg_regs.sv
rtl/pelc_match.sv
rtl/pelc_step.sv
rtl/pin_entry_lock_controller_core.sv
tb/sv/tb_pelc_status_check.sv
tb/sv/tb_pin_entry_lock_controller_core.sv
